### rtl/core/ibt_pkg.sv
// ibt_pkg: shared types, codes and double compare helpers for the interval
// bound tightener. No dependencies.
package ibt_pkg;

	localparam logic [10:0] EXP_ONE = 11'd1023;
	localparam logic [52:0] MANT_ONE = 53'h10_0000_0000_0000;

	localparam logic [1:0] ST_NOT_FILTERED = 2'd0;
	localparam logic [1:0] ST_NO_CHANGE    = 2'd1;
	localparam logic [1:0] ST_CHANGE       = 2'd2;

	localparam logic [2:0] CMD_EQ = 3'd0;
	localparam logic [2:0] CMD_NE = 3'd1;
	localparam logic [2:0] CMD_GT = 3'd2;
	localparam logic [2:0] CMD_GE = 3'd3;
	localparam logic [2:0] CMD_LT = 3'd4;
	localparam logic [2:0] CMD_LE = 3'd5;

	localparam logic [1:0] KIND_CONT = 2'd0;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_EQ,
		OP_LOWER,
		OP_SLOWER,
		OP_UPPER,
		OP_SUPPER
	} op_t;

	function automatic logic f_nan(input logic [63:0] a);
		f_nan = (a[62:0] > 63'h7FF0_0000_0000_0000);
	endfunction

	// a <= b with ieee rules
	function automatic logic f_le(input logic [63:0] a, input logic [63:0] b);
		logic r;
		r = 1'b0;
		if (f_nan(a) || f_nan(b)) begin
			r = 1'b0;
		end else if (a[62:0] == 63'd0 && b[62:0] == 63'd0) begin
			r = 1'b1;
		end else if (a[63] != b[63]) begin
			r = a[63];
		end else if (!a[63]) begin
			r = (a[62:0] <= b[62:0]);
		end else begin
			r = (a[62:0] >= b[62:0]);
		end
		f_le = r;
	endfunction

	function automatic logic f_eq(input logic [63:0] a, input logic [63:0] b);
		f_eq = !f_nan(a) && !f_nan(b) &&
			((a == b) || (a[62:0] == 63'd0 && b[62:0] == 63'd0));
	endfunction

	function automatic logic [63:0] f_step_up(input logic [63:0] b);
		logic [63:0] r;
		if (f_nan(b) || b == 64'h7FF0_0000_0000_0000) begin
			r = b;
		end else if (b[62:0] == 63'd0) begin
			r = 64'd1;
		end else if (!b[63]) begin
			r = b + 64'd1;
		end else begin
			r = b - 64'd1;
		end
		f_step_up = r;
	endfunction

endpackage

### rtl/core/interval_bound_tightener.sv
// interval_bound_tightener: tightens a variable's double interval from one
// simple relation per item. Depends on ibt_pkg.
// Throughput: one item per cycle while out_ready stays high; each stage holds independently under stall.
// The five stages are decode/align, add, leading zero count, normalise, round/compare.
// Reset (arst_n low, asynchronous) clears all stage valid bits; no other state.
module interval_bound_tightener (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic        polarity,
	input  logic        var_on_left,
	input  logic [1:0]  var_kind,
	input  logic [63:0] constant_bits,
	input  logic [63:0] lower_in,
	input  logic [63:0] upper_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] lower_out,
	output logic [63:0] upper_out,
	output logic        box_empty
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || out_ready;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// decode and align
	ibt_pkg::op_t op_d;
	logic gt_p, ge_p;
	logic [10:0] ea, ea_eff, e_big_d, exp_gap;
	logic [52:0] ma, big_d, small_d;
	logic a_big, sb, clampd;
	logic [5:0] sh;
	logic [112:0] wide;

	always_comb begin
		gt_p = polarity;
		ge_p = polarity;
		if (cmd == ibt_pkg::CMD_LT) ge_p = !polarity;
		if (cmd == ibt_pkg::CMD_LE) gt_p = !polarity;
		case (cmd)
			ibt_pkg::CMD_EQ: op_d = polarity ? ibt_pkg::OP_EQ : ibt_pkg::OP_NONE;
			ibt_pkg::CMD_NE: op_d = polarity ? ibt_pkg::OP_NONE : ibt_pkg::OP_EQ;
			ibt_pkg::CMD_GT, ibt_pkg::CMD_LE: begin
				if (var_on_left) op_d = gt_p ? ibt_pkg::OP_SLOWER : ibt_pkg::OP_UPPER;
				else op_d = gt_p ? ibt_pkg::OP_SUPPER : ibt_pkg::OP_LOWER;
			end
			ibt_pkg::CMD_GE, ibt_pkg::CMD_LT: begin
				if (var_on_left) op_d = ge_p ? ibt_pkg::OP_LOWER : ibt_pkg::OP_SUPPER;
				else op_d = ge_p ? ibt_pkg::OP_UPPER : ibt_pkg::OP_SLOWER;
			end
			default: op_d = ibt_pkg::OP_NONE;
		endcase
		sb = (op_d == ibt_pkg::OP_SUPPER);
		ea = constant_bits[62:52];
		ma = {ea != 11'd0, constant_bits[51:0]};
		ea_eff = (ea == 11'd0) ? 11'd1 : ea;
		a_big = (ea_eff >= ibt_pkg::EXP_ONE);
		big_d = a_big ? ma : ibt_pkg::MANT_ONE;
		small_d = a_big ? ibt_pkg::MANT_ONE : ma;
		e_big_d = a_big ? ea_eff : ibt_pkg::EXP_ONE;
		exp_gap = a_big ? (ea_eff - ibt_pkg::EXP_ONE) : (ibt_pkg::EXP_ONE - ea_eff);
		clampd = (exp_gap > 11'd57);
		sh = clampd ? 6'd57 : exp_gap[5:0];
		wide = {small_d, 3'b000, 57'd0} >> sh;
	end

	ibt_pkg::op_t op_s1, op_s2, op_s3, op_s4;
	logic [1:0] kind_s1, kind_s2, kind_s3, kind_s4;
	logic [63:0] c_s1, c_s2, c_s3, c_s4, lo_s1, lo_s2, lo_s3, lo_s4;
	logic [63:0] hi_s1, hi_s2, hi_s3, hi_s4;
	logic sgn_s1, sgn_s2, sgn_s3, sgn_s4, sub_s1;
	logic [10:0] eb_s1, eb_s2, eb_s3;
	logic [52:0] big_s1;
	logic [55:0] al_s1;
	logic [56:0] sum_s2, sum_s3, sum_s4;
	logic [63:0] step_s2, step_s3, step_s4;
	logic [5:0] lz_s3;
	logic [55:0] nrm_s4;
	logic [11:0] ex_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	logic [63:0] step_d;
	logic [56:0] sum_d;
	logic [5:0] lz_d;
	logic [55:0] nrm_d;
	logic [11:0] ex_d;

	always_comb begin
		if (op_s1 == ibt_pkg::OP_SUPPER)
			step_d = ibt_pkg::f_step_up({!c_s1[63], c_s1[62:0]}) ^ {1'b1, 63'd0};
		else
			step_d = ibt_pkg::f_step_up(c_s1);
		if (sub_s1) sum_d = {1'b0, big_s1, 3'b000} - {1'b0, al_s1};
		else sum_d = {1'b0, big_s1, 3'b000} + {1'b0, al_s1};
	end

	always_comb begin
		lz_d = 6'd56;
		for (int i = 0; i < 56; i++) begin
			if (sum_s2[i]) lz_d = 6'(55 - i);
		end
	end

	// normalise
	always_comb begin
		if (sum_s3[56]) begin
			nrm_d = {sum_s3[56:2], sum_s3[1] | sum_s3[0]};
			ex_d = {1'b0, eb_s3} + 12'd1;
		end else begin
			nrm_d = sum_s3[55:0] << lz_s3;
			ex_d = {1'b0, eb_s3} - {6'd0, lz_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			op_s1 <= op_d;
			kind_s1 <= var_kind;
			c_s1 <= constant_bits;
			lo_s1 <= lower_in;
			hi_s1 <= upper_in;
			sgn_s1 <= a_big ? constant_bits[63] : sb;
			sub_s1 <= constant_bits[63] ^ sb;
			eb_s1 <= e_big_d;
			big_s1 <= big_d;
			al_s1 <= {wide[112:58], wide[57] | (|wide[56:0])};
		end
		if (rdy2 && v_s1) begin
			op_s2 <= op_s1;
			kind_s2 <= kind_s1;
			c_s2 <= c_s1;
			lo_s2 <= lo_s1;
			hi_s2 <= hi_s1;
			sgn_s2 <= sgn_s1;
			eb_s2 <= eb_s1;
			sum_s2 <= sum_d;
			step_s2 <= step_d;
		end
		if (rdy3 && v_s2) begin
			op_s3 <= op_s2;
			kind_s3 <= kind_s2;
			c_s3 <= c_s2;
			lo_s3 <= lo_s2;
			hi_s3 <= hi_s2;
			sgn_s3 <= sgn_s2;
			eb_s3 <= eb_s2;
			sum_s3 <= sum_s2;
			step_s3 <= step_s2;
			lz_s3 <= lz_d;
		end
		if (rdy4 && v_s3) begin
			op_s4 <= op_s3;
			kind_s4 <= kind_s3;
			c_s4 <= c_s3;
			lo_s4 <= lo_s3;
			hi_s4 <= hi_s3;
			sgn_s4 <= sgn_s3;
			sum_s4 <= sum_s3;
			step_s4 <= step_s3;
			nrm_s4 <= nrm_d;
			ex_s4 <= ex_d;
		end
	end

	// round, then compare and tighten
	logic rnd;
	logic [62:0] mag;
	logic [63:0] addr, nb;
	logic [1:0] st_d;
	logic [63:0] lo_d, hi_d;
	logic emp_d;

	always_comb begin
		rnd = nrm_s4[2] && (nrm_s4[1] || nrm_s4[0] || nrm_s4[3]);
		mag = {ex_s4[10:0], nrm_s4[54:3]} + {62'd0, rnd};
		if (c_s4[62:52] == 11'h7FF) addr = c_s4;
		else if (sum_s4 == 57'd0) addr = 64'd0;
		else addr = {sgn_s4, mag};

		if (op_s4 == ibt_pkg::OP_SLOWER || op_s4 == ibt_pkg::OP_SUPPER)
			nb = (kind_s4 == ibt_pkg::KIND_CONT) ? step_s4 : addr;
		else
			nb = c_s4;

		st_d = ibt_pkg::ST_CHANGE;
		lo_d = lo_s4;
		hi_d = hi_s4;
		emp_d = 1'b0;
		case (op_s4)
			ibt_pkg::OP_EQ: begin
				if (ibt_pkg::f_eq(lo_s4, hi_s4) && ibt_pkg::f_eq(lo_s4, nb)) begin
					st_d = ibt_pkg::ST_NO_CHANGE;
				end else if (ibt_pkg::f_le(lo_s4, nb) && ibt_pkg::f_le(nb, hi_s4)) begin
					lo_d = nb;
					hi_d = nb;
				end else begin
					emp_d = 1'b1;
				end
			end
			ibt_pkg::OP_LOWER, ibt_pkg::OP_SLOWER: begin
				if (ibt_pkg::f_le(nb, lo_s4)) st_d = ibt_pkg::ST_NO_CHANGE;
				else if (ibt_pkg::f_le(nb, hi_s4)) lo_d = nb;
				else emp_d = 1'b1;
			end
			ibt_pkg::OP_UPPER, ibt_pkg::OP_SUPPER: begin
				if (ibt_pkg::f_le(hi_s4, nb)) st_d = ibt_pkg::ST_NO_CHANGE;
				else if (ibt_pkg::f_le(lo_s4, nb)) hi_d = nb;
				else emp_d = 1'b1;
			end
			default: st_d = ibt_pkg::ST_NOT_FILTERED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (rdy5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			status <= st_d;
			lower_out <= lo_d;
			upper_out <= hi_d;
			box_empty <= emp_d;
		end
	end

	assign out_valid = v_s5;

`ifndef SYNTH
	a_empty_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && box_empty |-> status == ibt_pkg::ST_CHANGE)
		else $error("empty box without change status");
	a_nf_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ibt_pkg::ST_NOT_FILTERED |-> !box_empty)
		else $error("unfiltered item flagged empty");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("bad status code");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(lower_out) && $stable(status))
		else $error("result lost under stall");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> in_ready)
		else $error("input stalled with empty first stage");
`endif

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for interval_bound_tightener; predicts each result
// from the item's relation and bounds, working on double bit patterns.
// Depends on ibt_pkg and the interval_bound_tightener rtl.
module tb_top;

	typedef struct {
		logic [2:0]  cmd;
		logic        pol;
		logic        left;
		logic [1:0]  kind;
		logic [63:0] cst;
		logic [63:0] lo;
		logic [63:0] hi;
		bit          drain;
	} bound_item_t;

	typedef struct {
		logic [1:0]  st;
		logic [63:0] lo;
		logic [63:0] hi;
		logic        empty;
	} bound_res_t;

	localparam int N_RANDOM    = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
	localparam logic [63:0] POS_MAX = 64'h7FEF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic polarity = 1'b0;
	logic var_on_left = 1'b0;
	logic [1:0] var_kind = '0;
	logic [63:0] constant_bits = '0;
	logic [63:0] lower_in = '0;
	logic [63:0] upper_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [63:0] lower_out;
	logic [63:0] upper_out;
	logic box_empty;

	bound_item_t pending_items[$];
	bound_res_t  expected_bounds[$];
	bound_item_t cur;
	int n_accepted = 0;
	int n_checked = 0;
	int n_errors = 0;
	int n_empty = 0;
	int n_changed = 0;
	int cycles = 0;

	interval_bound_tightener u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .polarity(polarity), .var_on_left(var_on_left), .var_kind(var_kind),
		.constant_bits(constant_bits), .lower_in(lower_in), .upper_in(upper_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .lower_out(lower_out), .upper_out(upper_out),
		.box_empty(box_empty)
	);

	always #10 clk = ~clk;

	// adjacent double towards plus infinity
	function automatic logic [63:0] next_above(logic [63:0] b);
		if (b[62:0] > POS_INF[62:0] || b == POS_INF) return b;
		if (b[62:0] == 63'd0) return 64'd1;
		return b[63] ? b - 64'd1 : b + 64'd1;
	endfunction

	function automatic logic [63:0] next_below(logic [63:0] b);
		logic [63:0] r;
		r = next_above({~b[63], b[62:0]});
		return {~r[63], r[62:0]};
	endfunction

	function automatic bound_res_t tighten(bound_item_t it);
		bound_res_t r;
		ibt_pkg::op_t op;
		logic p;
		logic [63:0] nb;
		real nv;
		r.st = ibt_pkg::ST_NOT_FILTERED;
		r.lo = it.lo;
		r.hi = it.hi;
		r.empty = 1'b0;
		op = ibt_pkg::OP_NONE;
		p = (it.cmd == ibt_pkg::CMD_LT || it.cmd == ibt_pkg::CMD_LE) ? !it.pol : it.pol;
		case (it.cmd)
			ibt_pkg::CMD_EQ: op = it.pol ? ibt_pkg::OP_EQ : ibt_pkg::OP_NONE;
			ibt_pkg::CMD_NE: op = it.pol ? ibt_pkg::OP_NONE : ibt_pkg::OP_EQ;
			ibt_pkg::CMD_GT, ibt_pkg::CMD_LE: begin
				if (it.left) op = p ? ibt_pkg::OP_SLOWER : ibt_pkg::OP_UPPER;
				else op = p ? ibt_pkg::OP_SUPPER : ibt_pkg::OP_LOWER;
			end
			ibt_pkg::CMD_GE, ibt_pkg::CMD_LT: begin
				if (it.left) op = p ? ibt_pkg::OP_LOWER : ibt_pkg::OP_SUPPER;
				else op = p ? ibt_pkg::OP_UPPER : ibt_pkg::OP_SLOWER;
			end
			default: op = ibt_pkg::OP_NONE;
		endcase
		nb = it.cst;
		if (op == ibt_pkg::OP_SLOWER) begin
			nb = (it.kind == ibt_pkg::KIND_CONT) ? next_above(it.cst) :
				$realtobits($bitstoreal(it.cst) + 1.0);
			op = ibt_pkg::OP_LOWER;
		end else if (op == ibt_pkg::OP_SUPPER) begin
			nb = (it.kind == ibt_pkg::KIND_CONT) ? next_below(it.cst) :
				$realtobits($bitstoreal(it.cst) - 1.0);
			op = ibt_pkg::OP_UPPER;
		end
		nv = $bitstoreal(nb);
		case (op)
			ibt_pkg::OP_EQ: begin
				if ($bitstoreal(it.lo) == $bitstoreal(it.hi) && $bitstoreal(it.lo) == nv) begin
					r.st = ibt_pkg::ST_NO_CHANGE;
				end else begin
					r.st = ibt_pkg::ST_CHANGE;
					if ($bitstoreal(it.lo) <= nv && nv <= $bitstoreal(it.hi)) begin
						r.lo = nb;
						r.hi = nb;
					end else r.empty = 1'b1;
				end
			end
			ibt_pkg::OP_LOWER: begin
				if (nv <= $bitstoreal(it.lo)) r.st = ibt_pkg::ST_NO_CHANGE;
				else begin
					r.st = ibt_pkg::ST_CHANGE;
					if (nv <= $bitstoreal(it.hi)) r.lo = nb;
					else r.empty = 1'b1;
				end
			end
			ibt_pkg::OP_UPPER: begin
				if (nv >= $bitstoreal(it.hi)) r.st = ibt_pkg::ST_NO_CHANGE;
				else begin
					r.st = ibt_pkg::ST_CHANGE;
					if (nv >= $bitstoreal(it.lo)) r.hi = nb;
					else r.empty = 1'b1;
				end
			end
			default: ;
		endcase
		if (r.empty) begin
			r.lo = it.lo;
			r.hi = it.hi;
		end
		return r;
	endfunction

	// random double, never a nan
	function automatic logic [63:0] pick_double(logic [63:0] near);
		logic [63:0] b;
		int k;
		k = $urandom_range(0, 9);
		case (k)
			0, 1, 2: b = $realtobits(real'($urandom_range(0, 16)) - 8.0);
			3: begin
				case ($urandom_range(0, 7))
					0: b = POS_INF;
					1: b = NEG_INF;
					2: b = 64'd0;
					3: b = NEG_ZERO;
					4: b = POS_MAX;
					5: b = {1'b1, POS_MAX[62:0]};
					6: b = {$urandom_range(0, 1) == 1, 63'd1};
					default: b = {$urandom_range(0, 1) == 1, 11'd0, $urandom, 20'd0};
				endcase
			end
			4: b = near;
			5: b = next_above(near);
			6: b = next_below(near);
			7: b = $realtobits($bitstoreal(near) + ($urandom_range(0, 1) ? 1.0 : -1.0));
			default: begin
				b = {$urandom, $urandom};
				if (b[62:52] == 11'h7FF) b[51:0] = '0;
			end
		endcase
		if (b[62:0] > POS_INF[62:0]) b = near;
		return b;
	endfunction

	function automatic bound_item_t make_item(logic [2:0] c);
		bound_item_t it;
		logic [63:0] t;
		it.cmd = c;
		it.pol = 1'($urandom_range(0, 1));
		it.left = 1'($urandom_range(0, 1));
		it.kind = 2'($urandom_range(0, 3));
		it.cst = pick_double($realtobits(real'($urandom_range(0, 6)) - 3.0));
		it.lo = pick_double(it.cst);
		it.hi = pick_double(it.cst);
		if ($urandom_range(0, 9) < 8 && $bitstoreal(it.lo) > $bitstoreal(it.hi)) begin
			t = it.lo;
			it.lo = it.hi;
			it.hi = t;
		end
		if ($urandom_range(0, 19) == 0) begin
			it.lo = it.cst;
			it.hi = it.cst;
		end
		it.drain = 1'b0;
		return it;
	endfunction

	function automatic int sender_idle_pct(int n);
		if (n < 500) return 33;
		if (n < 1000) return 71;
		return 0;
	endfunction

	function automatic int receiver_idle_pct(int n);
		if (n < 500) return 71;
		if (n < 1000) return 33;
		return 0;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_bounds.push_back(tighten(cur));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() > 0
						&& $urandom_range(0, 99) >= sender_idle_pct(n_accepted)
						&& !(pending_items[0].drain
							&& (n_accepted != n_checked || (in_valid && in_ready)))) begin
					cur = pending_items.pop_front();
					in_valid <= 1'b1;
					cmd <= cur.cmd;
					polarity <= cur.pol;
					var_on_left <= cur.left;
					var_kind <= cur.kind;
					constant_bits <= cur.cst;
					lower_in <= cur.lo;
					upper_in <= cur.hi;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		bound_res_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				n_checked <= n_checked + 1;
				if (expected_bounds.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected item: status %0d lo %h hi %h empty %0d",
							status, lower_out, upper_out, box_empty);
				end else begin
					e = expected_bounds.pop_front();
					if (e.empty) n_empty++;
					if (e.st == ibt_pkg::ST_CHANGE) n_changed++;
					if (status !== e.st || lower_out !== e.lo || upper_out !== e.hi
							|| box_empty !== e.empty) begin
						n_errors++;
						if (n_errors <= 10)
							$display("item %0d exp %0d %h %h %0d got %0d %h %h %0d",
								n_checked, e.st, e.lo, e.hi, e.empty,
								status, lower_out, upper_out, box_empty);
					end
				end
			end
			out_ready <= $urandom_range(0, 99) >= receiver_idle_pct(n_accepted);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		bound_item_t it;
		logic [63:0] specials[8];
		specials = '{64'd0, NEG_ZERO, POS_INF, NEG_INF, POS_MAX, {1'b1, POS_MAX[62:0]},
			64'd1, 64'h8000_0000_0000_0001};
		// every code with every side and kind spread over them
		for (int c = 0; c < 8; c++) begin
			it = make_item(c[2:0]);
			it.pol = c[0];
			it.left = c[1];
			it.kind = c[1:0];
			pending_items.push_back(it);
		end
		// extreme constants with strict relation codes of both polarities and wide bounds
		for (int s = 0; s < 8; s++) begin
			it = make_item(s[0] ? ibt_pkg::CMD_GT : ibt_pkg::CMD_LT);
			it.cst = specials[s];
			it.kind = ibt_pkg::KIND_CONT;
			it.pol = s[1];
			it.left = s[2];
			it.lo = NEG_INF;
			it.hi = POS_INF;
			pending_items.push_back(it);
		end
		it = make_item(ibt_pkg::CMD_EQ);
		it.pol = 1'b1;
		it.lo = it.cst;
		it.hi = it.cst;
		pending_items.push_back(it);
		it.cmd = ibt_pkg::CMD_NE;
		it.pol = 1'b0;
		it.hi = POS_INF;
		pending_items.push_back(it);
		it = make_item(ibt_pkg::CMD_GE);
		it.lo = {32'hFFFF_FFFF, 32'hFFFF_FFFF} & POS_MAX;
		it.hi = {1'b1, 63'h7FFF_FFFF_FFFF_FFFF} & {1'b1, POS_MAX[62:0]};
		it.cst = 64'h7FEF_FFFF_0000_0000;
		pending_items.push_back(it);
		for (int i = 0; i < N_RANDOM; i++) begin
			it = make_item(3'($urandom_range(0, 7)));
			it.drain = (i % 300 == 150);
			pending_items.push_back(it);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || in_valid || n_checked != n_accepted)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("checked %0d items over all relation codes, sides and kinds", n_checked);
		$display("%0d tightened the interval, %0d emptied the box", n_changed, n_empty);
		if (n_errors == 0 && expected_bounds.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, expected_bounds.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### interval_bound_tightener.f
rtl/core/ibt_pkg.sv
rtl/core/interval_bound_tightener.sv
verif/tb_top.sv
